// File: rtl/bsed_pkg.sv
package bsed_pkg;

    // Decoder modes
    localparam logic [2:0] MODE_PLAIN  = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_XSTART = 3'd2;
    localparam logic [2:0] MODE_XONE   = 3'd3;
    localparam logic [2:0] MODE_BRACE  = 3'd4;

    // Significant characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;

    // Largest Unicode code point
    localparam logic [31:0] CP_MAX = 32'h0010_FFFF;

    // Results that one source byte produces, handed to the output stage
    typedef struct packed {
        logic            load;      // at least one result
        logic [3:0][7:0] bytes;     // result bytes, first in [0]
        logic [1:0]      last_idx;  // result count minus one
        logic            bare;      // single end marker without data
        logic            done;      // group closes the string
    } group_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

// File: rtl/bsed_core.sv
module bsed_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 is_last,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    output bsed_pkg::group_t     grp
);

    logic [2:0]  mode_reg,  mode_next;
    logic [31:0] accum_reg, accum_next;
    logic        seen_reg,  seen_next;
    logic        binary_mode_reg;

    logic [3:0][7:0] obytes;
    logic [2:0]      n;
    logic            pass;
    logic            bare;
    logic [3:0]      d;
    logic            hex;
    logic [7:0]      v;
    logic [20:0]     cp;

    assign d   = bsed_pkg::hex_val(in_byte);
    assign hex = bsed_pkg::is_hex(in_byte);
    assign v   = {accum_reg[3:0], d};
    assign cp  = accum_reg[20:0];

    // Decode one source byte against the current mode
    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        seen_next  = seen_reg;
        obytes     = '0;
        n          = 3'd0;
        pass       = 1'b0;
        bare       = 1'b0;

        unique case (mode_reg)
            bsed_pkg::MODE_ESC:
            begin
                mode_next = bsed_pkg::MODE_PLAIN;
                unique case (in_byte)
                    bsed_pkg::CH_ZERO: begin obytes[0] = 8'h00; n = 3'd1; end
                    bsed_pkg::CH_B:    begin obytes[0] = 8'h08; n = 3'd1; end
                    bsed_pkg::CH_F:    begin obytes[0] = 8'h0C; n = 3'd1; end
                    bsed_pkg::CH_N:    begin obytes[0] = 8'h0A; n = 3'd1; end
                    bsed_pkg::CH_R:    begin obytes[0] = 8'h0D; n = 3'd1; end
                    bsed_pkg::CH_T:    begin obytes[0] = 8'h09; n = 3'd1; end
                    bsed_pkg::CH_X:    mode_next = bsed_pkg::MODE_XSTART;
                    default:
                    begin
                        if (!bsed_pkg::is_alnum(in_byte))
                        begin
                            obytes[0] = in_byte;
                            n         = 3'd1;
                        end
                    end
                endcase
            end
            bsed_pkg::MODE_XSTART:
            begin
                if (!binary_mode_reg && in_byte == bsed_pkg::CH_LBRACE)
                begin
                    mode_next  = bsed_pkg::MODE_BRACE;
                    accum_next = '0;
                    seen_next  = 1'b0;
                end
                else if (hex)
                begin
                    accum_next = {28'd0, d};
                    mode_next  = bsed_pkg::MODE_XONE;
                end
                else
                begin
                    mode_next  = bsed_pkg::MODE_PLAIN;
                    accum_next = '0;
                    seen_next  = 1'b0;
                    pass       = 1'b1;
                end
            end
            bsed_pkg::MODE_XONE:
            begin
                mode_next  = bsed_pkg::MODE_PLAIN;
                accum_next = '0;
                seen_next  = 1'b0;
                if (hex)
                begin
                    if (binary_mode_reg || !v[7])
                    begin
                        obytes[0] = v;
                        n         = 3'd1;
                    end
                end
                else
                begin
                    // held digit goes out, then the byte is plain input
                    obytes[0] = {4'd0, accum_reg[3:0]};
                    n         = 3'd1;
                    pass      = 1'b1;
                end
            end
            bsed_pkg::MODE_BRACE:
            begin
                if (hex && accum_reg[31:28] == 4'd0)
                begin
                    accum_next = {accum_reg[27:0], d};
                    seen_next  = 1'b1;
                end
                else
                begin
                    mode_next  = bsed_pkg::MODE_PLAIN;
                    accum_next = '0;
                    seen_next  = 1'b0;
                    if (!hex && in_byte == bsed_pkg::CH_RBRACE)
                    begin
                        // closing brace: UTF-8 encode the code point
                        if (seen_reg && accum_reg <= bsed_pkg::CP_MAX)
                        begin
                            if (cp < 21'h80)
                            begin
                                obytes[0] = cp[7:0];
                                n         = 3'd1;
                            end
                            else if (cp < 21'h800)
                            begin
                                obytes[0] = {3'b110, cp[10:6]};
                                obytes[1] = {2'b10, cp[5:0]};
                                n         = 3'd2;
                            end
                            else if (cp < 21'h10000)
                            begin
                                obytes[0] = {4'b1110, cp[15:12]};
                                obytes[1] = {2'b10, cp[11:6]};
                                obytes[2] = {2'b10, cp[5:0]};
                                n         = 3'd3;
                            end
                            else
                            begin
                                obytes[0] = {5'b11110, cp[20:18]};
                                obytes[1] = {2'b10, cp[17:12]};
                                obytes[2] = {2'b10, cp[11:6]};
                                obytes[3] = {2'b10, cp[5:0]};
                                n         = 3'd4;
                            end
                        end
                    end
                    else
                    begin
                        // overflowing digit or stray byte: escape dropped
                        pass = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = bsed_pkg::MODE_PLAIN;
                pass      = 1'b1;
            end
        endcase

        // Plain copy of the byte, possibly opening a new escape
        if (pass)
        begin
            if (in_byte == bsed_pkg::CH_BSLASH)
            begin
                mode_next = bsed_pkg::MODE_ESC;
            end
            else
            begin
                obytes[n[1:0]] = in_byte;
                n              = n + 3'd1;
            end
        end

        // End of string: flush a held digit, clear state, mark the end
        if (is_last)
        begin
            if (mode_next == bsed_pkg::MODE_XONE)
            begin
                obytes[n[1:0]] = {4'd0, accum_next[3:0]};
                n              = n + 3'd1;
            end
            mode_next  = bsed_pkg::MODE_PLAIN;
            accum_next = '0;
            seen_next  = 1'b0;
            if (n == 3'd0)
            begin
                bare = 1'b1;
                n    = 3'd1;
            end
        end
    end

    assign grp.load     = accept && (n != 3'd0);
    assign grp.bytes    = obytes;
    assign grp.last_idx = 2'(n - 3'd1);
    assign grp.bare     = bare;
    assign grp.done     = is_last;

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bsed_pkg::MODE_PLAIN;
            accum_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
            seen_reg  <= seen_next;
        end
    end

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binary_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            binary_mode_reg <= cfg_data;
        end
    end

    // A string end leaves no escape open
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_last |=> mode_reg == bsed_pkg::MODE_PLAIN && !seen_reg &&
                              accum_reg == '0)
        else $error("escape state survived end of string");

    // One held digit never carries more than a nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == bsed_pkg::MODE_XONE |-> accum_reg[31:4] == '0)
        else $error("held hex digit wider than a nibble");

    // Digits are only flagged inside braces
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> mode_reg == bsed_pkg::MODE_BRACE)
        else $error("digit flag set outside braces");

endmodule

// File: rtl/bsed_serial.sv
module bsed_serial
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 in_ready,
    input  bsed_pkg::group_t     grp,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    logic            grp_valid_reg;
    logic [3:0][7:0] bytes_reg;
    logic [1:0]      last_idx_reg;
    logic            bare_reg;
    logic            done_reg;
    logic [1:0]      idx_reg;

    logic beat;
    logic drain;
    logic accept;
    logic at_end;

    assign at_end   = idx_reg == last_idx_reg;
    assign beat     = grp_valid_reg && m_tready;
    assign drain    = beat && at_end;
    assign in_ready = !grp_valid_reg || drain;
    assign accept   = s_tvalid && in_ready;

    // Control: group present and beat index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (accept && grp.load)
        begin
            grp_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (drain)
        begin
            grp_valid_reg <= 1'b0;
        end
        else if (beat)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Group payload
    always_ff @(posedge clk)
    begin
        if (accept && grp.load)
        begin
            bytes_reg    <= grp.bytes;
            last_idx_reg <= grp.last_idx;
            bare_reg     <= grp.bare;
            done_reg     <= grp.done;
        end
    end

    assign m_tvalid = grp_valid_reg;
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tuser  = {at_end, !bare_reg};
    assign m_tlast  = done_reg && at_end;

    // Beat index stays within the group
    assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> idx_reg <= last_idx_reg)
        else $error("beat index past end of group");

    // A fresh group starts at its first byte
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && grp.load |=> grp_valid_reg && idx_reg == '0)
        else $error("group not loaded at first beat");

    // No new byte taken while a group is still being sent
    assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg && !drain |-> !in_ready)
        else $error("input taken over a pending group");

endmodule

// File: rtl/backslash_escape_decoder.sv
// Channel   Direction  Signals                               Payload
// s_*       in         s_tvalid s_tready s_tdata s_tlast     source byte, end of string
// m_*       out        m_tvalid m_tready m_tdata m_tuser     decoded byte, flags,
//                      m_tlast                               end of string
// cfg_*     in         cfg_valid cfg_ready cfg_data          binary_mode
//
// A source byte is decoded in the cycle it is taken; its results show on m_* from
// the next cycle, one byte per transaction.
// A byte giving k results (k from 1 to 4) holds s_tready low until its last result leaves
// the single output register group; bytes giving one or no result stream at one per cycle
// while m_tready is high. Input is taken on the cycle the last result of a group leaves.
// rst_n is asynchronous: plain copy mode, no pending results, binary_mode 0.
// cfg_ready is always high; writes take effect on the next byte.
module backslash_escape_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] run_last
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    bsed_pkg::group_t grp;
    logic             accept;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    bsed_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (s_tdata),
        .is_last   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .grp       (grp)
    );

    bsed_serial u_serial
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .grp      (grp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Decoder states as tracked by the predictor
    typedef enum logic [2:0] {
        DM_PLAIN  = 3'd0,
        DM_ESC    = 3'd1,
        DM_XSTART = 3'd2,
        DM_XONE   = 3'd3,
        DM_BRACE  = 3'd4
    } dec_mode_e;

    // Characters with a meaning to the decoder
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_0      = 8'h30;
    localparam logic [7:0] C_B      = 8'h62;
    localparam logic [7:0] C_F      = 8'h66;
    localparam logic [7:0] C_N      = 8'h6E;
    localparam logic [7:0] C_R      = 8'h72;
    localparam logic [7:0] C_T      = 8'h74;
    localparam logic [7:0] C_X      = 8'h78;

    localparam logic [31:0] TOP_CODE_POINT = 32'h0010_FFFF;
    localparam int          HOLD_CYCLES    = 80;

    // One decoded output transaction
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       run_last;
        logic       done;
    } dec_res_t;

    // All results of one source byte, first in res[0]
    typedef struct packed {
        logic [2:0]         count;
        dec_res_t [3:0]     res;
    } dec_group_t;

    // Directed row: source byte, end of string, and an optional hand-written result
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       known;
        logic [7:0] t_byte;
        logic       t_valid;
    } vec_row_t;

    localparam int N_VEC = 26;

    vec_row_t vectors [0:N_VEC-1] = '{
        '{8'hFF,    1'b0, 1'b1, 8'hFF, 1'b1},   // top byte copied
        '{8'h00,    1'b0, 1'b1, 8'h00, 1'b1},   // bottom byte copied
        '{C_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
        '{C_0,      1'b0, 1'b1, 8'h00, 1'b1},   // \0
        '{C_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
        '{C_T,      1'b1, 1'b1, 8'h09, 1'b1},   // \t closing a string
        '{C_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
        '{C_X,      1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h34,    1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h67,    1'b0, 1'b0, 8'h00, 1'b0},   // non-hex ends \x4: held digit, then byte
        '{C_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
        '{C_X,      1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h7A,    1'b0, 1'b1, 8'h7A, 1'b1},   // \x with no digit: byte copied
        '{C_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
        '{C_X,      1'b0, 1'b0, 8'h00, 1'b0},
        '{C_LBRACE, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h65,    1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h39,    1'b0, 1'b0, 8'h00, 1'b0},
        '{C_RBRACE, 1'b0, 1'b0, 8'h00, 1'b0},   // two-byte UTF-8
        '{C_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
        '{C_X,      1'b0, 1'b0, 8'h00, 1'b0},
        '{C_LBRACE, 1'b0, 1'b0, 8'h00, 1'b0},
        '{C_RBRACE, 1'b1, 1'b1, 8'h00, 1'b0},   // empty braces at the end: bare marker
        '{C_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
        '{C_X,      1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h37,    1'b1, 1'b1, 8'h07, 1'b1}    // held digit flushed at the end
    };

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    // Predictor state
    dec_mode_e   pr_mode   = DM_PLAIN;
    logic [31:0] pr_accum  = 32'h0;
    logic        pr_seen   = 1'b0;
    logic        pr_binary = 1'b0;

    dec_res_t    pending_decoded [$];
    logic [7:0]  text_q [$];
    int          fail_count      = 0;
    int          results_checked = 0;
    int          bytes_sent      = 0;
    int          strings_sent    = 0;
    int          holds_done      = 0;

    backslash_escape_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] in_byte
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] out_byte
        .m_tuser   (m_tuser),   // [0] byte_valid, [1] run_last
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bit 4 flags a hex digit, bits 3:0 its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else
        begin
            return 5'h00;
        end
        return {1'b1, v[3:0]};
    endfunction

    function automatic logic letter_or_digit(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (c >= 8'h30 && c <= 8'h39) || (folded >= 8'h61 && folded <= 8'h7A);
    endfunction

    function automatic dec_group_t push_out(input dec_group_t g, input logic [7:0] b);
        if (g.count < 3'd4)
        begin
            g.res[g.count[1:0]].data     = b;
            g.res[g.count[1:0]].valid    = 1'b1;
            g.res[g.count[1:0]].run_last = 1'b0;
            g.res[g.count[1:0]].done     = 1'b0;
            g.count = g.count + 3'd1;
        end
        return g;
    endfunction

    function automatic void drop_escape();
        pr_mode  = DM_PLAIN;
        pr_accum = 32'h0;
        pr_seen  = 1'b0;
    endfunction

    // A byte outside any escape: backslash opens one, anything else is copied
    function automatic dec_group_t copy_plain(input dec_group_t g, input logic [7:0] c);
        if (c == C_BSLASH)
        begin
            pr_mode = DM_ESC;
        end
        else
        begin
            g = push_out(g, c);
        end
        return g;
    endfunction

    // Advances the predictor by one source byte and returns what it should produce
    function automatic dec_group_t decode_byte(input logic [7:0] c, input logic fin);
        dec_group_t  g;
        logic [4:0]  nib;
        logic [7:0]  pair;
        logic [31:0] cp;
        g   = '0;
        nib = hex_nibble(c);
        case (pr_mode)
            DM_ESC:
            begin
                pr_mode = DM_PLAIN;
                case (c)
                    C_0:     g = push_out(g, 8'h00);
                    C_B:     g = push_out(g, 8'h08);
                    C_F:     g = push_out(g, 8'h0C);
                    C_N:     g = push_out(g, 8'h0A);
                    C_R:     g = push_out(g, 8'h0D);
                    C_T:     g = push_out(g, 8'h09);
                    C_X:     pr_mode = DM_XSTART;
                    default:
                    begin
                        if (!letter_or_digit(c))
                        begin
                            g = push_out(g, c);
                        end
                    end
                endcase
            end
            DM_XSTART:
            begin
                if (!pr_binary && c == C_LBRACE)
                begin
                    pr_mode  = DM_BRACE;
                    pr_accum = 32'h0;
                    pr_seen  = 1'b0;
                end
                else if (nib[4])
                begin
                    pr_accum = {28'h0, nib[3:0]};
                    pr_mode  = DM_XONE;
                end
                else
                begin
                    drop_escape();
                    g = copy_plain(g, c);
                end
            end
            DM_XONE:
            begin
                if (nib[4])
                begin
                    pair = {pr_accum[3:0], nib[3:0]};
                    if (pr_binary || !pair[7])
                    begin
                        g = push_out(g, pair);
                    end
                    drop_escape();
                end
                else
                begin
                    g = push_out(g, {4'h0, pr_accum[3:0]});
                    drop_escape();
                    g = copy_plain(g, c);
                end
            end
            DM_BRACE:
            begin
                if (nib[4])
                begin
                    // a ninth significant nibble would not fit: escape dropped, digit copied
                    if (pr_accum[31:28] != 4'h0)
                    begin
                        drop_escape();
                        g = copy_plain(g, c);
                    end
                    else
                    begin
                        pr_accum = {pr_accum[27:0], nib[3:0]};
                        pr_seen  = 1'b1;
                    end
                end
                else if (c == C_RBRACE)
                begin
                    cp = pr_accum;
                    if (pr_seen && cp <= TOP_CODE_POINT)
                    begin
                        if (cp < 32'h80)
                        begin
                            g = push_out(g, cp[7:0]);
                        end
                        else if (cp < 32'h800)
                        begin
                            g = push_out(g, {3'b110, cp[10:6]});
                            g = push_out(g, {2'b10, cp[5:0]});
                        end
                        else if (cp < 32'h10000)
                        begin
                            g = push_out(g, {4'b1110, cp[15:12]});
                            g = push_out(g, {2'b10, cp[11:6]});
                            g = push_out(g, {2'b10, cp[5:0]});
                        end
                        else
                        begin
                            g = push_out(g, {5'b11110, cp[20:18]});
                            g = push_out(g, {2'b10, cp[17:12]});
                            g = push_out(g, {2'b10, cp[11:6]});
                            g = push_out(g, {2'b10, cp[5:0]});
                        end
                    end
                    drop_escape();
                end
                else
                begin
                    drop_escape();
                    g = copy_plain(g, c);
                end
            end
            default:
            begin
                pr_mode = DM_PLAIN;
                g = copy_plain(g, c);
            end
        endcase

        // End of string: flush a held digit, always close with one result
        if (fin)
        begin
            if (pr_mode == DM_XONE)
            begin
                g = push_out(g, {4'h0, pr_accum[3:0]});
            end
            drop_escape();
            if (g.count == 3'd0)
            begin
                g.count  = 3'd1;
                g.res[0] = '0;
            end
            g.res[2'(g.count - 3'd1)].done = 1'b1;
        end
        if (g.count != 3'd0)
        begin
            g.res[2'(g.count - 3'd1)].run_last = 1'b1;
        end
        return g;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(8, 30);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return 8'h30 + v;
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    // One source transaction; the expected results are queued once it is taken
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic no_gaps,
                             input logic known, input logic [7:0] t_byte,
                             input logic t_valid);
        int         gap;
        int         k;
        dec_group_t grp;
        dec_res_t   one;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 99) < 30)
        begin
            gap = gap_len();
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
        grp = decode_byte(b, fin);
        if (known)
        begin
            one.data     = t_byte;
            one.valid    = t_valid;
            one.run_last = 1'b1;
            one.done     = fin;
            pending_decoded.push_back(one);
        end
        else
        begin
            for (k = 0; k < grp.count; k++)
            begin
                pending_decoded.push_back(grp.res[2'(k)]);
            end
        end
    endtask

    // Sender stops and waits for every outstanding result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_decoded.size() != 0) @(posedge clk);
    endtask

    task automatic set_binary(input logic v);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        pr_binary = v;
    endtask

    // Builds one random string from well-formed escapes, broken ones and noise
    task automatic compose_text();
        int         segs;
        int         kind;
        int         n;
        int         k;
        int         j;
        logic [3:0] nib;
        logic [7:0] b;
        text_q.delete();
        segs = $urandom_range(1, 6);
        for (k = 0; k < segs; k++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                b = 8'($urandom_range(0, 255));
                text_q.push_back(b);
            end
            else if (kind < 40)
            begin
                text_q.push_back(C_BSLASH);
                case ($urandom_range(0, 9))
                    0:       text_q.push_back(C_0);
                    1:       text_q.push_back(C_B);
                    2:       text_q.push_back(C_F);
                    3:       text_q.push_back(C_N);
                    4:       text_q.push_back(C_R);
                    5:       text_q.push_back(C_T);
                    default:
                    begin
                        b = 8'($urandom_range(0, 255));
                        text_q.push_back(b);
                    end
                endcase
            end
            else if (kind < 58)
            begin
                // \x with zero to two digits
                text_q.push_back(C_BSLASH);
                text_q.push_back(C_X);
                n = $urandom_range(0, 2);
                for (j = 0; j < n; j++)
                begin
                    nib = 4'($urandom_range(0, 15));
                    text_q.push_back(hex_char(nib));
                end
            end
            else if (kind < 85)
            begin
                // braced code point, sometimes empty, overlong or unclosed
                text_q.push_back(C_BSLASH);
                text_q.push_back(C_X);
                text_q.push_back(C_LBRACE);
                j = $urandom_range(0, 19);
                if (j == 0)
                begin
                    n = 0;
                end
                else if (j < 4)
                begin
                    n = $urandom_range(9, 11);
                end
                else
                begin
                    n = $urandom_range(1, 6);
                end
                for (j = 0; j < n; j++)
                begin
                    nib = 4'($urandom_range(0, 15));
                    if (j == 0 && n > 8 && nib == 4'h0)
                    begin
                        nib = 4'h1;
                    end
                    text_q.push_back(hex_char(nib));
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    text_q.push_back(C_RBRACE);
                end
                else
                begin
                    b = 8'($urandom_range(0, 255));
                    text_q.push_back(b);
                end
            end
            else
            begin
                n = $urandom_range(1, 3);
                for (j = 0; j < n; j++)
                begin
                    b = 8'($urandom_range(0, 255));
                    text_q.push_back(b);
                end
            end
        end
    endtask

    task automatic run_random(input int quota);
        int   sent_here;
        int   k;
        logic burst;
        sent_here = 0;
        while (sent_here < quota)
        begin
            compose_text();
            burst = ($urandom_range(0, 3) == 0);
            for (k = 0; k < text_q.size(); k++)
            begin
                send_byte(text_q[k], k == text_q.size() - 1, burst, 1'b0, 8'h00, 1'b0);
            end
            sent_here += text_q.size();
            strings_sent++;
            if ($urandom_range(0, 14) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    // Compares one output transaction with the oldest expectation
    task automatic take_result();
        dec_res_t got;
        dec_res_t want;
        got.data     = m_tdata;
        got.valid    = m_tuser[0];
        got.run_last = m_tuser[1];
        got.done     = m_tlast;
        results_checked++;
        if (pending_decoded.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("unexpected result: byte %02h valid %b run_last %b done %b",
                         got.data, got.valid, got.run_last, got.done);
            end
        end
        else
        begin
            want = pending_decoded.pop_front();
            if (got !== want)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("result %0d: expected byte %02h valid %b run_last %b done %b",
                             results_checked, want.data, want.valid, want.run_last,
                             want.done);
                    $display("result %0d:      got byte %02h valid %b run_last %b done %b",
                             results_checked, got.data, got.valid, got.run_last, got.done);
                end
            end
        end
    endtask

    // Output side: random stalls, quiet stretches and two long hold-offs
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int quiet_left;
        stall_left = 0;
        hold_left  = 0;
        quiet_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                take_result();
            end
            if (quiet_left > 0)
            begin
                quiet_left--;
            end
            else if ($urandom_range(0, 99) < 3)
            begin
                quiet_left = $urandom_range(20, 60);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (holds_done < 2 && results_checked >= 30 + holds_done * 120)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (quiet_left == 0 && $urandom_range(0, 99) < 25)
            begin
                stall_left = gap_len() - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus: directed table, then random strings under changing binary_mode
    initial
    begin : source_side
        int i;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_VEC; i++)
        begin
            send_byte(vectors[i].data, vectors[i].fin, 1'b0, vectors[i].known,
                      vectors[i].t_byte, vectors[i].t_valid);
        end
        strings_sent += 3;

        set_binary(1'b1);
        run_random(60);
        set_binary(1'b0);
        run_random(60);
        set_binary(1'b1);
        run_random(60);

        wait_drained();
        repeat (16) @(posedge clk);

        $display("Sent %0d source bytes in %0d strings, checked %0d decoded results",
                 bytes_sent, strings_sent, results_checked);
        $display("binary_mode run at 0 and 1, output held off %0d times for %0d cycles",
                 holds_done, HOLD_CYCLES);
        if (fail_count == 0 && pending_decoded.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
